[rtl/core/cfd_pkg.sv]
// shared constants, types and crc helper for the frame deframer
`default_nettype none
package cfd_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int BYTE_W = 8;
	localparam int PLEN_W = 6;
	localparam int LIMIT_W = 6;
	localparam int CRC_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = QPTR_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT = 2'd2;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
	localparam logic [LIMIT_W-1:0] LENGTH_LIMIT_RST = 6'd32;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
		logic [LIMIT_W-1:0] length_limit;
	} cfg_t;

	typedef struct packed {
		logic status;
		logic [BYTE_W-1:0] command;
		logic [BYTE_W-1:0] seqno;
		logic [LEN_W-1:0] length;
	} desc_t;

	typedef struct packed {
		logic en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} wr_t;

	typedef struct packed {
		logic q_full;
		logic store_busy;
	} hold_t;

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/core/cfd_if.sv]
// request channel interfaces: received bytes, results, register writes
`default_nettype none
interface cfd_rx_if;
	import cfd_pkg::*;
	logic valid;
	logic ready;
	logic [BYTE_W-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_res_if;
	import cfd_pkg::*;
	logic valid;
	logic ready;
	logic status;
	logic [BYTE_W-1:0] command;
	logic [BYTE_W-1:0] sequence_res;
	logic [PLEN_W-1:0] payload_length;
	logic has_data;
	logic [BYTE_W-1:0] data_byte;
	logic last;
	modport source (output valid, output status, output command, output sequence_res,
		output payload_length, output has_data, output data_byte, output last,
		input ready);
	modport sink (input valid, input status, input command, input sequence_res,
		input payload_length, input has_data, input data_byte, input last,
		output ready);
endinterface

interface cfd_cfg_if;
	import cfd_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/cfd_front.sv]
// frame parser: sync hunt, header capture, crc and payload store writes
`default_nettype none
module cfd_front (
	input wire logic clk,
	input wire logic arst_n,
	cfd_rx_if.sink rx,
	input wire cfd_pkg::cfg_t cfg_regs,
	input wire cfd_pkg::hold_t hold,
	output cfd_pkg::wr_t wr,
	output logic push,
	output cfd_pkg::desc_t push_desc
);
	import cfd_pkg::*;

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_SYNC2 = 3'd1;
	localparam logic [2:0] PH_LEN = 3'd2;
	localparam logic [2:0] PH_CMD = 3'd3;
	localparam logic [2:0] PH_SEQ = 3'd4;
	localparam logic [2:0] PH_DATA = 3'd5;
	localparam logic [2:0] PH_CRCLO = 3'd6;
	localparam logic [2:0] PH_CRCHI = 3'd7;

	logic [2:0] phase_q;
	logic [LEN_W-1:0] len_q;
	logic [BYTE_W-1:0] cmd_q;
	logic [BYTE_W-1:0] seq_q;
	logic [LEN_W-1:0] idx_q;
	logic [BYTE_W-1:0] crc_lo_q;
	logic [CRC_W-1:0] crc_q;

	logic acc;
	logic [BYTE_W-1:0] b;
	logic [BYTE_W-1:0] limit;
	logic [LEN_W-1:0] idx_inc;
	logic [CRC_W-1:0] crc_next;

	assign rx.ready = !((phase_q == PH_DATA) && hold.store_busy) &&
		!((phase_q == PH_CRCHI) && hold.q_full);
	assign acc = rx.valid && rx.ready;
	assign b = rx.rx_byte;
	assign limit = (BYTE_W'(cfg_regs.length_limit) < BYTE_W'(MAX_PAYLOAD)) ?
		BYTE_W'(cfg_regs.length_limit) : BYTE_W'(MAX_PAYLOAD);
	assign idx_inc = LEN_W'(idx_q + 1'b1);
	assign crc_next = crc_byte(crc_q, b);

	assign wr.en = acc && (phase_q == PH_DATA);
	assign wr.addr = idx_q[ADDR_W-1:0];
	assign wr.data = b;

	assign push = acc && (phase_q == PH_CRCHI);
	assign push_desc.status = ({b, crc_lo_q} != crc_q);
	assign push_desc.command = cmd_q;
	assign push_desc.seqno = seq_q;
	assign push_desc.length = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			idx_q <= '0;
			crc_q <= CRC_INIT;
		end else if (acc) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (b == cfg_regs.sync_first) phase_q <= PH_SYNC2;
				end
				PH_SYNC2: begin
					if (b == cfg_regs.sync_second) begin
						phase_q <= PH_LEN;
						crc_q <= CRC_INIT;
					end else if (b != cfg_regs.sync_first) begin
						phase_q <= PH_HUNT;
					end
				end
				PH_LEN: begin
					crc_q <= crc_next;
					phase_q <= (b > limit) ? PH_HUNT : PH_CMD;
				end
				PH_CMD: begin
					crc_q <= crc_next;
					phase_q <= PH_SEQ;
				end
				PH_SEQ: begin
					crc_q <= crc_next;
					idx_q <= '0;
					phase_q <= (len_q != '0) ? PH_DATA : PH_CRCLO;
				end
				PH_DATA: begin
					crc_q <= crc_next;
					idx_q <= idx_inc;
					if (idx_inc >= len_q) phase_q <= PH_CRCLO;
				end
				PH_CRCLO: begin
					phase_q <= PH_CRCHI;
				end
				PH_CRCHI: begin
					phase_q <= PH_HUNT;
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if ((phase_q == PH_LEN) && (b <= limit)) len_q <= LEN_W'(b);
			if (phase_q == PH_CMD) cmd_q <= b;
			if (phase_q == PH_SEQ) seq_q <= b;
			if (phase_q == PH_CRCLO) crc_lo_q <= b;
		end
	end

endmodule
`default_nettype wire

[rtl/core/cfd_queue.sv]
// two-entry descriptor queue between parser and result sequencer
`default_nettype none
module cfd_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire cfd_pkg::desc_t push_desc,
	input wire logic pop,
	output cfd_pkg::desc_t head,
	output logic empty,
	output logic full
);
	import cfd_pkg::*;

	desc_t ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			if (pop) rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			if (push && !pop) begin
				cnt_q <= QCNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= QCNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_desc;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("descriptor pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("descriptor popped from an empty queue");

endmodule
`default_nettype wire

[rtl/core/cfd_back.sv]
// payload store and result sequencer with registered output
`default_nettype none
module cfd_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfd_pkg::wr_t wr,
	input wire cfd_pkg::desc_t head,
	input wire logic q_empty,
	output logic pop,
	output logic busy,
	cfd_res_if.source res
);
	import cfd_pkg::*;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_ONE = 2'd1;
	localparam logic [1:0] B_BURST = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	desc_t cur_q;
	logic [LEN_W-1:0] idx_q;
	logic [LEN_W-1:0] idx_d;
	logic [LEN_W-1:0] idx_inc;
	logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
	logic [BYTE_W-1:0] rd_data_q;
	logic slot_free;
	logic load;
	logic is_last;

	logic out_valid_q;
	logic status_q;
	logic [BYTE_W-1:0] command_q;
	logic [BYTE_W-1:0] seq_q;
	logic [PLEN_W-1:0] plen_q;
	logic has_data_q;
	logic [BYTE_W-1:0] data_q;
	logic last_q;

	assign slot_free = !out_valid_q || res.ready;
	assign idx_inc = LEN_W'(idx_q + 1'b1);
	assign is_last = (idx_inc == cur_q.length);
	assign busy = (state_q != B_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		pop = 1'b0;
		load = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					idx_d = '0;
					state_d = (head.status || (head.length == '0)) ? B_ONE : B_BURST;
				end
			end
			B_ONE: begin
				if (slot_free) begin
					load = 1'b1;
					state_d = B_IDLE;
				end
			end
			B_BURST: begin
				if (slot_free) begin
					load = 1'b1;
					if (is_last) begin
						state_d = B_IDLE;
					end else begin
						idx_d = idx_inc;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (load) begin
			status_q <= cur_q.status;
			command_q <= cur_q.command;
			seq_q <= cur_q.seqno;
			plen_q <= PLEN_W'(cur_q.length);
			has_data_q <= (state_q == B_BURST);
			data_q <= (state_q == B_BURST) ? rd_data_q : '0;
			last_q <= (state_q == B_ONE) || is_last;
		end
	end

	// payload store, read one entry ahead of the result register
	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr] <= wr.data;
		rd_data_q <= mem[idx_d[ADDR_W-1:0]];
	end

	assign res.valid = out_valid_q;
	assign res.status = status_q;
	assign res.command = command_q;
	assign res.sequence_res = seq_q;
	assign res.payload_length = plen_q;
	assign res.has_data = has_data_q;
	assign res.data_byte = data_q;
	assign res.last = last_q;

	a_store_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == B_IDLE) && q_empty)
		else $error("payload store written while a frame is pending");

	a_burst_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_BURST) |-> (idx_q < cur_q.length))
		else $error("burst index past frame length");

endmodule
`default_nettype wire

[rtl/core/crc_checked_frame_deframer_core.sv]
// top level of the crc checked frame deframer
// Usage:
//   rx carries one received byte per request; res carries results; cfg writes
//   register 0 (first sync byte), 1 (second sync byte), 2 (length limit).
//   cfg is always ready and should be written only while the block is idle.
// Throughput: the parser takes one byte per cycle. It holds rx.ready low on a
//   payload byte while an earlier frame still waits in the descriptor queue or
//   is being read out of the payload store, and on the crc high byte while the
//   two-entry queue is full.
// Result path: after the crc high byte is taken, the descriptor passes through the
//   queue, the sequencer's cur_q register and the output register; a burst then
//   delivers one payload byte per cycle while res.ready is high, limited by the
//   single read port of the payload store. Reset: arst_n clears the parser to sync
//   hunt, empties the queue, drops any pending result and restores the register
//   defaults. The payload store is not cleared.
// Stalls: results are held in an output register until res.ready; the parser
//   keeps taking header bytes of the next frame meanwhile.
`default_nettype none
module crc_checked_frame_deframer_core (
	input wire logic clk,
	input wire logic arst_n,
	cfd_rx_if.sink rx,
	cfd_res_if.source res,
	cfd_cfg_if.sink cfg
);
	import cfd_pkg::*;

	cfg_t cfg_q;
	hold_t hold;
	wr_t wr;
	logic push;
	desc_t push_desc;
	logic pop;
	desc_t head;
	logic q_empty;
	logic q_full;
	logic back_busy;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first <= SYNC_FIRST_RST;
			cfg_q.sync_second <= SYNC_SECOND_RST;
			cfg_q.length_limit <= LENGTH_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SYNC_FIRST: cfg_q.sync_first <= cfg.data;
				REG_SYNC_SECOND: cfg_q.sync_second <= cfg.data;
				REG_LENGTH_LIMIT: cfg_q.length_limit <= cfg.data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign hold.q_full = q_full;
	assign hold.store_busy = !q_empty || back_busy;

	cfd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.cfg_regs(cfg_q),
		.hold(hold),
		.wr(wr),
		.push(push),
		.push_desc(push_desc)
	);

	cfd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_desc(push_desc),
		.pop(pop),
		.head(head),
		.empty(q_empty),
		.full(q_full)
	);

	cfd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.head(head),
		.q_empty(q_empty),
		.pop(pop),
		.busy(back_busy),
		.res(res)
	);

endmodule
`default_nettype wire

[bench/crc_checked_frame_deframer_core_test.sv]
// self-checking bench for the frame deframer core: framed byte traffic, shadow parser, result checks
module crc_checked_frame_deframer_core_test;
	import cfd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_CRC_BAD = 1'b1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_MAX = 10;

	typedef enum logic [2:0] {
		SEEK_SYNC1, SEEK_SYNC2, GET_LEN, GET_CMD, GET_SEQ, GET_DATA, GET_CRC_LO, GET_CRC_HI
	} parse_state_e;

	typedef struct packed {
		logic status;
		logic [BYTE_W-1:0] command;
		logic [BYTE_W-1:0] seqno;
		logic [PLEN_W-1:0] length;
		logic has_data;
		logic [BYTE_W-1:0] data;
		logic last;
	} frame_res_t;

	class deframer_shadow;
		logic [BYTE_W-1:0] first_sync;
		logic [BYTE_W-1:0] second_sync;
		logic [LIMIT_W-1:0] len_cap;
		parse_state_e state;
		logic [PLEN_W-1:0] flen;
		logic [BYTE_W-1:0] fcmd;
		logic [BYTE_W-1:0] fseq;
		logic [BYTE_W-1:0] crc_lo;
		logic [CRC_W-1:0] crc;
		int idx;
		logic [BYTE_W-1:0] payload_buf [MAX_PAYLOAD];
		frame_res_t due_results [$];
		int mismatches;

		function new();
			first_sync = SYNC_FIRST_RST;
			second_sync = SYNC_SECOND_RST;
			len_cap = LENGTH_LIMIT_RST;
			state = SEEK_SYNC1;
			flen = '0;
			fcmd = '0;
			fseq = '0;
			crc_lo = '0;
			crc = CRC_INIT;
			idx = 0;
			mismatches = 0;
		endfunction

		static function logic [CRC_W-1:0] crc_update(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
			logic [CRC_W-1:0] r;
			logic fb;
			r = c;
			for (int i = BYTE_W - 1; i >= 0; i--) begin
				fb = r[CRC_W-1] ^ b[i];
				r = {r[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
			end
			return r;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] index, logic [BYTE_W-1:0] data);
			case (index)
			REG_SYNC_FIRST: first_sync = data;
			REG_SYNC_SECOND: second_sync = data;
			REG_LENGTH_LIMIT: len_cap = data[LIMIT_W-1:0];
			default: ;
			endcase
		endfunction

		function void push(logic status, logic has, logic [BYTE_W-1:0] data, logic last);
			due_results.push_back({status, fcmd, fseq, flen, has, data, last});
		endfunction

		function void take_byte(logic [BYTE_W-1:0] b);
			int cap;
			cap = (len_cap < MAX_PAYLOAD) ? len_cap : MAX_PAYLOAD;
			case (state)
			SEEK_SYNC1: begin
				if (b == first_sync)
					state = SEEK_SYNC2;
			end
			SEEK_SYNC2: begin
				if (b == second_sync) begin
					state = GET_LEN;
					crc = CRC_INIT;
				end else if (b != first_sync) begin
					state = SEEK_SYNC1;
				end
			end
			GET_LEN: begin
				crc = crc_update(crc, b);
				if (b > cap) begin
					state = SEEK_SYNC1;
				end else begin
					flen = b[PLEN_W-1:0];
					state = GET_CMD;
				end
			end
			GET_CMD: begin
				fcmd = b;
				crc = crc_update(crc, b);
				state = GET_SEQ;
			end
			GET_SEQ: begin
				fseq = b;
				crc = crc_update(crc, b);
				idx = 0;
				state = (flen != 0) ? GET_DATA : GET_CRC_LO;
			end
			GET_DATA: begin
				payload_buf[idx] = b;
				idx++;
				crc = crc_update(crc, b);
				if (idx >= flen)
					state = GET_CRC_LO;
			end
			GET_CRC_LO: begin
				crc_lo = b;
				state = GET_CRC_HI;
			end
			default: begin
				if ({b, crc_lo} != crc) begin
					push(STATUS_CRC_BAD, 1'b0, '0, 1'b1);
				end else if (flen == 0) begin
					push(STATUS_OK, 1'b0, '0, 1'b1);
				end else begin
					for (int i = 0; i < flen; i++)
						push(STATUS_OK, 1'b1, payload_buf[i], (i + 1 == flen));
				end
				state = SEEK_SYNC1;
			end
			endcase
		endfunction

		function string show(frame_res_t r);
			return $sformatf("status=%0d cmd=%h seq=%h len=%0d has_data=%0d data=%h last=%0d",
				r.status, r.command, r.seqno, r.length, r.has_data, r.data, r.last);
		endfunction

		function void check_result(frame_res_t got);
			frame_res_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result with none expected: %s", show(got));
			end else begin
				want = due_results.pop_front();
				if (got.status !== want.status || got.command !== want.command ||
						got.seqno !== want.seqno || got.length !== want.length ||
						got.has_data !== want.has_data || got.data !== want.data ||
						got.last !== want.last) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("result mismatch: expected %s, got %s", show(want), show(got));
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int bytes_sent;
	int rx_calm;
	int res_calm;
	deframer_shadow sb;

	cfd_rx_if rx_ch ();
	cfd_res_if res_ch ();
	cfd_cfg_if cfg_ch ();

	crc_checked_frame_deframer_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("crc_checked_frame_deframer_core_test NOT OK");
		$finish;
	end

	task automatic draw_wait(inout int calm, output int w);
		if (calm > 0) begin
			calm--;
			w = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 40);
			w = 0;
		end else begin
			w = $urandom_range(0, 15);
		end
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		draw_wait(rx_calm, gap);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		sb.take_byte(b);
		bytes_sent++;
	endtask

	// keep < 0 sends the whole frame, fill < 0 gives random payload
	task automatic send_frame(input int len, input logic [BYTE_W-1:0] cmd,
			input logic [BYTE_W-1:0] seq, input bit bad_crc, input int keep, input int fill);
		logic [BYTE_W-1:0] fr [$];
		logic [CRC_W-1:0] c;
		c = CRC_INIT;
		fr.push_back(sb.first_sync);
		fr.push_back(sb.second_sync);
		fr.push_back(len[7:0]);
		fr.push_back(cmd);
		fr.push_back(seq);
		for (int i = 0; i < len; i++)
			fr.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : fill[7:0]);
		for (int i = 2; i < fr.size(); i++)
			c = deframer_shadow::crc_update(c, fr[i]);
		if (bad_crc)
			c ^= 16'($urandom_range(1, 16'hFFFF));
		fr.push_back(c[7:0]);
		fr.push_back(c[15:8]);
		if (keep >= 0) begin
			while (fr.size() > keep)
				void'(fr.pop_back());
		end
		foreach (fr[i])
			send_byte(fr[i]);
	endtask

	task automatic random_unit();
		int cap;
		int len;
		int pick;
		cap = (sb.len_cap < MAX_PAYLOAD) ? sb.len_cap : MAX_PAYLOAD;
		len = ($urandom_range(0, 5) == 0) ? cap : $urandom_range(0, (cap < 6) ? cap : 6);
		pick = $urandom_range(0, 15);
		case (pick)
		0, 1: begin
			repeat ($urandom_range(1, 4))
				send_byte(8'($urandom_range(0, 255)));
		end
		2: begin
			send_byte(sb.first_sync);
			send_frame(len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, -1, -1);
		end
		3: begin
			send_byte(sb.first_sync);
			send_byte(8'($urandom_range(0, 255)));
		end
		4: begin
			send_frame($urandom_range(cap + 1, 255), 8'($urandom_range(0, 255)), 8'h00,
				1'b0, 3, -1);
		end
		5: begin
			send_frame(len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0,
				$urandom_range(1, len + 6), -1);
		end
		default: begin
			send_frame(len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				($urandom_range(0, 7) == 0), -1, -1);
		end
		endcase
	endtask

	task automatic random_run(input int budget);
		int goal;
		goal = bytes_sent + budget;
		while (bytes_sent < goal)
			random_unit();
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [BYTE_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(index, data);
	endtask

	task automatic configure(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second,
			input logic [BYTE_W-1:0] limit);
		cfg_write(REG_SYNC_FIRST, first);
		cfg_write(REG_SYNC_SECOND, second);
		cfg_write(REG_LENGTH_LIMIT, limit);
		cfg_ch.valid <= 1'b0;
	endtask

	// drain all results, then give the pipeline time to go quiet
	task automatic settle();
		rx_ch.valid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int stall;
		frame_res_t got;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			draw_wait(res_calm, stall);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			got = {res_ch.status, res_ch.command, res_ch.sequence_res, res_ch.payload_length,
				res_ch.has_data, res_ch.data_byte, res_ch.last};
			sb.check_result(got);
		end
	end

	initial begin
		sb = new();
		bytes_sent = 0;
		rx_calm = 0;
		res_calm = 0;
		arst_n <= 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_SYNC_FIRST;
		cfg_ch.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// repeated first sync ahead of an empty frame with a bad crc
		send_byte(sb.first_sync);
		send_frame(0, 8'hFF, 8'h00, 1'b1, -1, -1);
		send_frame(0, 8'h00, 8'hFF, 1'b0, -1, -1);
		send_frame(1, 8'h5A, 8'hA5, 1'b0, -1, 8'hFF);
		send_byte(sb.first_sync);
		send_byte(8'h12);
		// length one above the maximum
		send_frame(MAX_PAYLOAD + 1, 8'h00, 8'h00, 1'b0, 3, -1);
		random_run(80);
		settle();

		configure(8'h00, 8'hFF, 8'd0);
		random_run(40);
		settle();

		// equal sync bytes, limit above the buffer size
		configure(8'h7E, 8'h7E, 8'd63);
		random_run(70);
		settle();

		cfg_write(REG_UNUSED, 8'hFF);
		configure(8'hFF, 8'h00, 8'd32);
		random_run(70);
		settle();

		configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(1, 63)));
		random_run(60);
		settle();

		if (sb.mismatches == 0 && sb.due_results.size() == 0)
			$display("crc_checked_frame_deframer_core_test OK");
		else
			$display("crc_checked_frame_deframer_core_test NOT OK");
		$finish;
	end

endmodule
